// ===== rtl/ezvr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezvr_pkg : shared constants and helpers for the Euler ZYX vector rotator
// Angle constants, CORDIC arctangent table and the trig-pair hand-off type.
// ----------------------------------------------------------------------------
package ezvr_pkg;

  localparam int unsigned COMPONENT_BITS_DEF  = 32;
  localparam int unsigned TRIG_ITERATIONS_DEF = 16;
  localparam int unsigned AtanEntries         = 24;

  // Angle constants in Q.20, held in 26 bits (range of a Q4.12 input << 8)
  localparam int unsigned AngW = 26;
  localparam logic signed [AngW-1:0] AngPi     = 26'sd3294199;
  localparam logic signed [AngW-1:0] AngHalfPi = 26'sd1647099;
  localparam logic signed [AngW-1:0] AngTwoPi  = 26'sd6588397;

  // CORDIC datapath in Q.30, 32 bits plus headroom
  localparam int unsigned CordW = 33;
  localparam logic signed [CordW-1:0] CordicGain = 33'sd652032874;

  // Trig outputs in Q1.14, 16 bits
  localparam int unsigned TrigW = 16;
  localparam logic signed [TrigW-1:0] TrigOne = 16'sd16384;

  // Arctangent of 2^-i in Q.20
  function automatic logic signed [AngW-1:0] atan_q20(input int unsigned i);
    logic signed [AngW-1:0] r;
    begin
      case (i)
        0: r = 26'sd823550;  1: r = 26'sd486170;  2: r = 26'sd256879;
        3: r = 26'sd130396;  4: r = 26'sd65451;   5: r = 26'sd32757;
        6: r = 26'sd16383;   7: r = 26'sd8192;    8: r = 26'sd4096;
        9: r = 26'sd2048;    10: r = 26'sd1024;   11: r = 26'sd512;
        12: r = 26'sd256;    13: r = 26'sd128;    14: r = 26'sd64;
        15: r = 26'sd32;     16: r = 26'sd16;     17: r = 26'sd8;
        18: r = 26'sd4;      19: r = 26'sd2;      20: r = 26'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // Sine/cosine pair for one axis
  typedef struct packed {
    logic signed [TrigW-1:0] s;
    logic signed [TrigW-1:0] c;
  } trig_t;

endpackage

// ===== rtl/ezvr_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezvr_sincos : pipelined sine/cosine lane
// Range-reduces a Q4.12 angle, runs a rotation-mode CORDIC with one
// register stage per step, then rounds to Q1.14.
// ----------------------------------------------------------------------------
module ezvr_sincos #(
  parameter int unsigned ITER = ezvr_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                          clk_i,
  input  logic signed [15:0]            angle_i,
  output ezvr_pkg::trig_t               trig_o
);
  import ezvr_pkg::*;

  localparam int unsigned N = (ITER > AtanEntries) ? AtanEntries : ITER;

  logic signed [AngW-1:0]  ang_raw, ang_w, ang_r;
  logic                    neg_r;

  logic signed [CordW-1:0] x_q [N+1];
  logic signed [CordW-1:0] y_q [N+1];
  logic signed [AngW-1:0]  a_q [N+1];
  logic                    n_q [N+1];
  trig_t                   trig_q;

  // Range reduction to [-pi/2, pi/2]
  always_comb begin
    ang_raw = AngW'(angle_i) <<< 8;
    ang_w   = ang_raw;
    neg_r   = 1'b0;
    if (ang_w > AngPi) ang_w = ang_w - AngTwoPi;
    if (ang_w < -AngPi) ang_w = ang_w + AngTwoPi;
    ang_r = ang_w;
    if (ang_w > AngHalfPi) begin
      ang_r = ang_w - AngPi;
      neg_r = 1'b1;
    end else if (ang_w < -AngHalfPi) begin
      ang_r = ang_w + AngPi;
      neg_r = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= CordicGain;
    y_q[0] <= '0;
    a_q[0] <= ang_r;
    n_q[0] <= neg_r;
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (a_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        a_q[i+1] <= a_q[i] - atan_q20(i);
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        a_q[i+1] <= a_q[i] + atan_q20(i);
      end
      n_q[i+1] <= n_q[i];
    end
  end

  function automatic logic signed [TrigW-1:0] trig_round(
    input logic signed [CordW-1:0] v, input logic neg);
    logic signed [CordW:0]   t;
    logic signed [CordW-16:0] r;
    logic signed [TrigW-1:0] o;
    begin
      t = (CordW+1)'(v) + (CordW+1)'(32768);
      r = t[CordW:16];
      if (r > (CordW-15)'(TrigOne)) o = TrigOne;
      else if (r < -(CordW-15)'(TrigOne)) o = -TrigOne;
      else o = r[TrigW-1:0];
      return neg ? -o : o;
    end
  endfunction

  // Round Q.30 to Q1.14 and apply half-turn sign
  always_ff @(posedge clk_i) begin
    trig_q.s <= trig_round(y_q[N], n_q[N]);
    trig_q.c <= trig_round(x_q[N], n_q[N]);
  end

  assign trig_o = trig_q;
endmodule

// ===== rtl/ezvr_rot2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezvr_rot2 : one planar rotation stage
// Forms u' = u*c - v*s and v' = u*s + v*c with rounding and clamp to
// +-(2^W - 1). Multiply stage registered, then sum/round/clamp registered.
// ----------------------------------------------------------------------------
module ezvr_rot2 #(
  parameter int unsigned W = ezvr_pkg::COMPONENT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic signed [W:0]      u_i,
  input  logic signed [W:0]      v_i,
  input  ezvr_pkg::trig_t        trig_i,
  input  logic                   sat_i,
  output logic signed [W:0]      u_o,
  output logic signed [W:0]      v_o,
  output logic                   sat_o
);
  import ezvr_pkg::*;

  localparam int unsigned PW = W + 1 + TrigW;
  localparam int unsigned SW = PW + 1;

  logic signed [PW-1:0] uc_q, vs_q, us_q, vc_q;
  logic                 sat1_q;
  logic signed [W:0]    u_q, v_q;
  logic                 sat2_q;
  logic signed [SW-1:0] su, sv;
  logic signed [SW-15:0] ru, rv;
  logic signed [W:0]    cu, cv;
  logic                 fu, fv;

  // Products
  always_ff @(posedge clk_i) begin
    uc_q   <= PW'(u_i) * PW'(trig_i.c);
    vs_q   <= PW'(v_i) * PW'(trig_i.s);
    us_q   <= PW'(u_i) * PW'(trig_i.s);
    vc_q   <= PW'(v_i) * PW'(trig_i.c);
    sat1_q <= sat_i;
  end

  function automatic logic signed [W:0] clampw(input logic signed [SW-15:0] r,
                                               output logic f);
    logic signed [SW-15:0] lim;
    begin
      lim = (SW-14)'((65'sd1 <<< W) - 65'sd1);
      f = 1'b0;
      if (r > lim) begin
        f = 1'b1;
        return lim[W:0];
      end
      if (r < -lim) begin
        f = 1'b1;
        return -lim[W:0];
      end
      return r[W:0];
    end
  endfunction

  // Sum, round, clamp
  always_comb begin
    su = SW'(uc_q) - SW'(vs_q) + SW'(8192);
    sv = SW'(us_q) + SW'(vc_q) + SW'(8192);
    ru = su[SW-1:14];
    rv = sv[SW-1:14];
    cu = clampw(ru, fu);
    cv = clampw(rv, fv);
  end

  always_ff @(posedge clk_i) begin
    u_q    <= cu;
    v_q    <= cv;
    sat2_q <= sat1_q | fu | fv;
  end

  assign u_o   = u_q;
  assign v_o   = v_q;
  assign sat_o = sat2_q;
endmodule

// ===== rtl/euler_zyx_vector_rotation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_zyx_vector_rotation : fixed-point ZYX Euler rotation of a 3D vector
// Three CORDIC lanes give the trig pairs; three rotation stages in series
// (Z, then Y, then X) merge them with the vector; the result is saturated.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high; busy is always low,
// so one vector is accepted per clock. Each result appears on out_*_o with
// done_o high for exactly one cycle, after the CORDIC lanes, the Z, Y and X
// rotation stages and the final clip register; the receiver cannot stall it.
module euler_zyx_vector_rotation #(
  parameter int unsigned COMPONENT_BITS  = ezvr_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned TRIG_ITERATIONS = ezvr_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COMPONENT_BITS-1:0] in_x_i,
  input  logic signed [COMPONENT_BITS-1:0] in_y_i,
  input  logic signed [COMPONENT_BITS-1:0] in_z_i,
  input  logic signed [15:0]               angle_x_i,
  input  logic signed [15:0]               angle_y_i,
  input  logic signed [15:0]               angle_z_i,
  output logic                             done_o,
  output logic signed [COMPONENT_BITS-1:0] out_x_o,
  output logic signed [COMPONENT_BITS-1:0] out_y_o,
  output logic signed [COMPONENT_BITS-1:0] out_z_o,
  output logic                             saturated_o
);
  import ezvr_pkg::*;

  localparam int unsigned W    = COMPONENT_BITS;
  localparam int unsigned NIT  = (TRIG_ITERATIONS > AtanEntries) ? AtanEntries
                                                                   : TRIG_ITERATIONS;
  localparam int unsigned TLAT = NIT + 2;
  localparam int unsigned LAT  = TLAT + 7;

  trig_t tx, ty, tz;
  logic  [LAT-1:0] vld_q;

  assign busy = 1'b0;

  // Trig lanes
  ezvr_sincos #(.ITER(TRIG_ITERATIONS)) u_trig_x (.clk_i, .angle_i(angle_x_i), .trig_o(tx));
  ezvr_sincos #(.ITER(TRIG_ITERATIONS)) u_trig_y (.clk_i, .angle_i(angle_y_i), .trig_o(ty));
  ezvr_sincos #(.ITER(TRIG_ITERATIONS)) u_trig_z (.clk_i, .angle_i(angle_z_i), .trig_o(tz));

  // Vector delay to match trig latency; later trig pairs delayed per stage
  logic signed [W-1:0] vx_q [TLAT];
  logic signed [W-1:0] vy_q [TLAT];
  logic signed [W-1:0] vz_q [TLAT];
  trig_t ty_q [2];
  trig_t tx_q [4];

  always_ff @(posedge clk_i) begin
    vx_q[0] <= in_x_i;
    vy_q[0] <= in_y_i;
    vz_q[0] <= in_z_i;
    for (int i = 1; i < TLAT; i++) begin
      vx_q[i] <= vx_q[i-1];
      vy_q[i] <= vy_q[i-1];
      vz_q[i] <= vz_q[i-1];
    end
    ty_q[0] <= ty;
    ty_q[1] <= ty_q[0];
    tx_q[0] <= tx;
    for (int i = 1; i < 4; i++) tx_q[i] <= tx_q[i-1];
  end

  // Stage Z: (x, y)
  logic signed [W:0] zx, zy;
  logic              zs;
  logic signed [W:0] z1_q, z2_q;
  ezvr_rot2 #(.W(W)) u_rot_z (
    .clk_i, .u_i((W+1)'(vx_q[TLAT-1])), .v_i((W+1)'(vy_q[TLAT-1])),
    .trig_i(tz), .sat_i(1'b0), .u_o(zx), .v_o(zy), .sat_o(zs));

  always_ff @(posedge clk_i) begin
    z1_q <= (W+1)'(vz_q[TLAT-1]);
    z2_q <= z1_q;
  end

  // Stage Y: (z, x) with c=cy, s=sy gives z'=z*cy-x*sy, x'=z*sy+x*cy
  logic signed [W:0] yz, yx;
  logic              ys;
  logic signed [W:0] y1_q, y2_q;
  ezvr_rot2 #(.W(W)) u_rot_y (
    .clk_i, .u_i(z2_q), .v_i(zx), .trig_i(ty_q[1]), .sat_i(zs),
    .u_o(yz), .v_o(yx), .sat_o(ys));

  always_ff @(posedge clk_i) begin
    y1_q <= zy;
    y2_q <= y1_q;
  end

  // Stage X: (y, z)
  logic signed [W:0] xy, xz;
  logic              xs;
  logic signed [W:0] x1_q, x2_q;
  ezvr_rot2 #(.W(W)) u_rot_x (
    .clk_i, .u_i(y2_q), .v_i(yz), .trig_i(tx_q[3]), .sat_i(ys),
    .u_o(xy), .v_o(xz), .sat_o(xs));

  always_ff @(posedge clk_i) begin
    x1_q <= yx;
    x2_q <= x1_q;
  end

  // Final clip to the signed component range
  function automatic logic signed [W-1:0] fin(input logic signed [W:0] v,
                                              output logic f);
    begin
      f = (v[W] != v[W-1]);
      if (f) return v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      return v[W-1:0];
    end
  endfunction

  logic signed [W-1:0] ox_d, oy_d, oz_d;
  logic fx, fy, fz;
  logic signed [W-1:0] ox_q, oy_q, oz_q;
  logic sat_q;

  always_comb begin
    ox_d = fin(x2_q, fx);
    oy_d = fin(xy, fy);
    oz_d = fin(xz, fz);
  end

  always_ff @(posedge clk_i) begin
    ox_q  <= ox_d;
    oy_q  <= oy_d;
    oz_q  <= oz_d;
    sat_q <= xs | fx | fy | fz;
  end

  // Valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start & ~busy};
    end
  end

  assign done_o      = vld_q[LAT-1];
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign saturated_o = sat_q;

  // Checks
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_done_tracks_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(vld_q[LAT-2]) |-> done_o) else $error("result lost");
  a_no_reset_done: assert property (@(posedge clk_i) !rst_ni |=> !done_o)
    else $error("done after reset");
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : self-checking bench for euler_zyx_vector_rotation
// Drives vectors and angle triples with random gaps and back-to-back bursts. A fixed-point model of
// the CORDIC trig and the ZYX rotation predicts each result, and a
// scoreboard compares every strobed output against it in order.
// ----------------------------------------------------------------------------

// Expected rotated vector, compared in request order
class rotation_scoreboard;
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } rot_res_t;

  rot_res_t   pending_q[$];
  int         errors;
  int         checked;
  bit         sat_seen;

  // floor((v + 2^15) / 2^16), clamped to +-1.0 in Q1.14
  static function longint trig_round(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  static function void trig_pair(logic signed [15:0] raw, output longint s,
                                 output longint c);
    longint a, x, y, dx, dy;
    bit     flip;
    a = longint'(raw) * 256;
    flip = 1'b0;
    x = ezvr_pkg::CordicGain;
    y = 0;
    if (a > ezvr_pkg::AngPi) a -= ezvr_pkg::AngTwoPi;
    if (a < -ezvr_pkg::AngPi) a += ezvr_pkg::AngTwoPi;
    if (a > ezvr_pkg::AngHalfPi) begin
      a -= ezvr_pkg::AngPi; flip = 1'b1;
    end else if (a < -ezvr_pkg::AngHalfPi) begin
      a += ezvr_pkg::AngPi; flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= ezvr_pkg::atan_q20(i);
      end else begin
        x += dx; y -= dy; a += ezvr_pkg::atan_q20(i);
      end
    end
    s = trig_round(y);
    c = trig_round(x);
    if (flip) begin
      s = -s; c = -c;
    end
  endfunction

  // One rotation term, clamped to +-(2^32 - 1)
  static function longint rot_term(longint a, longint p, longint b, longint q,
                                   inout bit sat);
    longint lim, r;
    lim = 64'sd4294967295;
    r = (a * p + b * q + 8192) >>> 14;
    if (r > lim) begin r = lim; sat = 1'b1; end
    if (r < -lim) begin r = -lim; sat = 1'b1; end
    return r;
  endfunction

  static function logic signed [31:0] clip32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin v = 64'sd2147483647; sat = 1'b1; end
    if (v < -64'sd2147483648) begin v = -64'sd2147483648; sat = 1'b1; end
    return v[31:0];
  endfunction

  function void note_request(logic signed [31:0] ix, iy, iz,
                             logic signed [15:0] ax, ay, az);
    longint   x, y, z, t, sx, cx, sy, cy, sz, cz;
    bit       sat;
    rot_res_t r;
    sat = 1'b0;
    x = ix; y = iy; z = iz;
    trig_pair(ax, sx, cx);
    trig_pair(ay, sy, cy);
    trig_pair(az, sz, cz);
    t = rot_term(x, cz, y, -sz, sat);
    y = rot_term(x, sz, y, cz, sat);
    x = t;
    t = rot_term(x, cy, z, sy, sat);
    z = rot_term(z, cy, x, -sy, sat);
    x = t;
    t = rot_term(y, cx, z, -sx, sat);
    z = rot_term(y, sx, z, cx, sat);
    y = t;
    r.x = clip32(x, sat);
    r.y = clip32(y, sat);
    r.z = clip32(z, sat);
    r.sat = sat;
    pending_q.push_back(r);
  endfunction

  function void check_result(logic signed [31:0] ox, oy, oz, logic osat);
    rot_res_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: result with none pending: x=%0d y=%0d z=%0d sat=%0b",
               $time, ox, oy, oz, osat);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    checked++;
    if (osat) sat_seen = 1'b1;
    if (ox !== e.x) begin
      $display("%0t: out_x expected %0d actual %0d", $time, e.x, ox); errors++;
    end
    if (oy !== e.y) begin
      $display("%0t: out_y expected %0d actual %0d", $time, e.y, oy); errors++;
    end
    if (oz !== e.z) begin
      $display("%0t: out_z expected %0d actual %0d", $time, e.z, oz); errors++;
    end
    if (osat !== e.sat) begin
      $display("%0t: saturated expected %0b actual %0b", $time, e.sat, osat);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int NumRandom = 400;
  localparam int IdleLimit = 2000;
  localparam int Latency   = 25;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [31:0] in_x_i, in_y_i, in_z_i;
  logic signed [15:0] angle_x_i, angle_y_i, angle_z_i;
  logic               done_o;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic               saturated_o;

  rotation_scoreboard sb;
  int                 idle_cycles;
  int                 sent;

  euler_zyx_vector_rotation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .angle_x_i   (angle_x_i),
    .angle_y_i   (angle_y_i),
    .angle_z_i   (angle_z_i),
    .done_o      (done_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .saturated_o (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Accepted requests feed the predictor, strobed results the checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        sb.note_request(in_x_i, in_y_i, in_z_i, angle_x_i, angle_y_i, angle_z_i);
        sent++;
      end
      if (done_o) sb.check_result(out_x_o, out_y_o, out_z_o, saturated_o);
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one request, then hold it until taken; unless burst is set, an idle gap drawn with $urandom_range comes first
  task automatic send_rotation(logic signed [31:0] x, y, z,
                               logic signed [15:0] ax, ay, az, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start     <= 1'b1;
    in_x_i    <= x;  in_y_i    <= y;  in_z_i    <= z;
    angle_x_i <= ax; angle_y_i <= ay; angle_z_i <= az;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 20'hfffff)) - 32'sd524288;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd6434;   // near pi/2
      3: return -16'sd12868; // near -pi
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    logic signed [15:0] angs[8];
    bit burst;
    sb = new();
    idle_cycles = 0;
    sent = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    in_x_i = '0; in_y_i = '0; in_z_i = '0;
    angle_x_i = '0; angle_y_i = '0; angle_z_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: angle wrap and quadrant folds, extremes, clipping
    angs = '{16'sd0, 16'sd6434, -16'sd6434, 16'sd12868, -16'sd12868,
             16'sd12869, 16'sh7fff, 16'sh8000};
    foreach (angs[i])
      send_rotation(32'sd65536, 32'sd131072, -32'sd65536, angs[i],
                    angs[(i + 3) % 8], angs[(i + 5) % 8], 1'b0);
    send_rotation(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sd0, 16'sd0, 16'sd0, 0);
    send_rotation(32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sd0, 16'sd0, 16'sd0, 0);
    send_rotation(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sd3217, 16'sd3217,
                  16'sd3217, 0);
    send_rotation(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'sh8000, 16'sh7fff,
                  -16'sd3217, 0);
    send_rotation(32'sd0, 32'sd0, 32'sd0, 16'sh7fff, 16'sh8000, 16'sh7fff, 1);
    send_rotation(-32'sd1, -32'sd1, -32'sd1, -16'sd1, -16'sd1, -16'sd1, 1);
    send_rotation(32'sd1, 32'sd1, 32'sd1, 16'sd1, 16'sd1, 16'sd1, 1);

    // Random: bursts at full rate alternate with gapped stretches
    for (int n = 0; n < NumRandom; n++) begin
      burst = ((n / 40) % 2) == 1;
      send_rotation(rand_comp(), rand_comp(), rand_comp(), rand_angle(),
                    rand_angle(), rand_angle(), burst);
    end
    start <= 1'b0;

    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);

    $display("Sent %0d rotations, checked %0d results; clipping seen: %0b",
             sent, sb.checked, sb.sat_seen);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
